>>> hw/rtl/ubt_pkg.sv
`default_nettype none
package ubt_pkg;

	// table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// field widths
	localparam int OP_W   = 2;
	localparam int PORT_W = 16;
	localparam int ADDR_W = 32;
	localparam int TAG_W  = 8;
	localparam int SLOT_W = 4;
	localparam int ST_W   = 2;
	localparam int CNT_W  = PORT_W + 1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EPH_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPH_HIGH = 1'b1;

	// reset values
	localparam logic [PORT_W-1:0] EPH_LOW_RST  = 16'd49152;
	localparam logic [PORT_W-1:0] EPH_HIGH_RST = 16'd65535;
	localparam logic [PORT_W-1:0] CURSOR_RST   = 16'd49152;

	typedef enum logic [OP_W-1:0] {
		OP_BIND   = 2'd0,
		OP_UNBIND = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_e;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_IN_USE    = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} st_e;

	typedef struct packed {
		op_e               operation;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] local_addr;
		logic [TAG_W-1:0]  owner_tag;
	} in_beat_t;

	typedef struct packed {
		st_e               status;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  owner_out;
		logic [PORT_W-1:0] alloc_port;
	} out_beat_t;

	// one stored binding
	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] addr;
		logic [TAG_W-1:0]  owner;
	} entry_t;

	// scan request from the controller
	typedef struct packed {
		logic              start;
		logic              use_addr;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] addr;
	} scan_req_t;

	// scan outcome, valid while done is high
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [TAG_W-1:0] hit_owner;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
	} scan_rsp_t;

	// table update
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [IDX_W-1:0]  idx;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] addr;
		logic [TAG_W-1:0]  owner;
	} tbl_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/ubt_table.sv
`default_nettype none
module ubt_table (
	input  logic                clk,
	input  logic                arst_n,
	input  ubt_pkg::scan_req_t  req,
	input  ubt_pkg::tbl_wr_t    wr,
	output ubt_pkg::scan_rsp_t  rsp
);

	// binding store, one read port, one write port
	ubt_pkg::entry_t                 mem_q [ubt_pkg::ENTRIES];
	logic [ubt_pkg::ENTRIES-1:0]     valid_q;

	logic                            issue_q;
	logic [ubt_pkg::IDX_W-1:0]       rd_ptr_q;
	logic                            chk_s1;
	logic [ubt_pkg::IDX_W-1:0]       chk_idx_s1;
	ubt_pkg::entry_t                 rd_s1;

	logic [ubt_pkg::PORT_W-1:0]      key_port_q;
	logic [ubt_pkg::ADDR_W-1:0]      key_addr_q;
	logic                            use_addr_q;
	logic                            free_found_q;
	logic [ubt_pkg::IDX_W-1:0]       free_idx_q;

	logic ent_valid;
	logic match;
	logic done;
	logic free_here;

	// compare stage on the registered read data
	always_comb begin
		ent_valid = valid_q[chk_idx_s1];
		match     = chk_s1 && ent_valid && (rd_s1.port == key_port_q) &&
			(!use_addr_q || (rd_s1.addr == '0) || (rd_s1.addr == key_addr_q));
		done      = chk_s1 && (match || (chk_idx_s1 == ubt_pkg::LAST_IDX));
		free_here = chk_s1 && !ent_valid;
	end

	assign rsp.done       = done;
	assign rsp.hit        = match;
	assign rsp.hit_idx    = chk_idx_s1;
	assign rsp.hit_owner  = rd_s1.owner;
	assign rsp.free_found = free_found_q || free_here;
	assign rsp.free_idx   = free_found_q ? free_idx_q : chk_idx_s1;

	// scan sequencer: address issue and check-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q      <= 1'b0;
			rd_ptr_q     <= '0;
			chk_s1       <= 1'b0;
			free_found_q <= 1'b0;
		end else if (req.start) begin
			issue_q      <= 1'b1;
			rd_ptr_q     <= '0;
			chk_s1       <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			chk_s1  <= issue_q && !done;
			issue_q <= issue_q && !done && (rd_ptr_q != ubt_pkg::LAST_IDX);
			if (issue_q && (rd_ptr_q != ubt_pkg::LAST_IDX)) begin
				rd_ptr_q <= rd_ptr_q + ubt_pkg::IDX_W'(1);
			end
			if (free_here) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// keys, read data and first free slot
	always_ff @(posedge clk) begin
		if (req.start) begin
			key_port_q <= req.port;
			key_addr_q <= req.addr;
			use_addr_q <= req.use_addr;
		end
		if (issue_q) begin
			rd_s1 <= mem_q[rd_ptr_q];
		end
		chk_idx_s1 <= rd_ptr_q;
		if (free_here && !free_found_q) begin
			free_idx_q <= chk_idx_s1;
		end
	end

	// memory write
	always_ff @(posedge clk) begin
		if (wr.set) begin
			mem_q[wr.idx] <= '{port: wr.port, addr: wr.addr, owner: wr.owner};
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.set) begin
			valid_q[wr.idx] <= 1'b1;
		end else if (wr.clr) begin
			valid_q[wr.idx] <= 1'b0;
		end
	end

	a_set_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr.set |-> !valid_q[wr.idx])
		else $error("bind writes an occupied slot");

	a_clr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.clr |-> valid_q[wr.idx])
		else $error("unbind clears an empty slot");

	a_done_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !req.start) |=> !chk_s1)
		else $error("check stage live after scan end");

endmodule
`default_nettype wire

>>> hw/rtl/ubt_ctrl.sv
`default_nettype none
module ubt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_take,
	input  ubt_pkg::in_beat_t          in_beat,
	input  logic [ubt_pkg::PORT_W-1:0] eph_low,
	input  logic [ubt_pkg::PORT_W-1:0] eph_high,
	input  logic                       out_free,
	output logic                       idle,
	output logic                       res_done,
	output ubt_pkg::out_beat_t         res,
	output ubt_pkg::scan_req_t         req,
	output ubt_pkg::tbl_wr_t           wr,
	input  ubt_pkg::scan_rsp_t         rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                      state_q;
	ubt_pkg::op_e                op_q;
	logic [ubt_pkg::PORT_W-1:0]  port_q;
	logic [ubt_pkg::ADDR_W-1:0]  addr_q;
	logic [ubt_pkg::TAG_W-1:0]   tag_q;
	logic [ubt_pkg::PORT_W-1:0]  cursor_q;
	logic [ubt_pkg::PORT_W-1:0]  cand_q;
	logic [ubt_pkg::CNT_W-1:0]   count_q;
	logic [ubt_pkg::CNT_W-1:0]   span_q;
	ubt_pkg::out_beat_t          res_q;

	logic [ubt_pkg::PORT_W-1:0]  cur_start;
	logic [ubt_pkg::PORT_W-1:0]  nxt_cand;
	logic [ubt_pkg::CNT_W-1:0]   span;
	logic                        range_bad;
	logic                        in_alloc;
	logic                        scan_done;
	logic                        alloc_retry;
	ubt_pkg::out_beat_t          res_nxt;

	// ephemeral range arithmetic
	always_comb begin
		range_bad = eph_low > eph_high;
		cur_start = ((cursor_q < eph_low) || (cursor_q > eph_high)) ? eph_low : cursor_q;
		nxt_cand  = (cand_q == eph_high) ? eph_low : cand_q + ubt_pkg::PORT_W'(1);
		span      = {1'b0, eph_high} - {1'b0, eph_low} + ubt_pkg::CNT_W'(1);
		in_alloc  = in_beat.operation == ubt_pkg::OP_ALLOC;
	end

	assign scan_done   = (state_q == S_SCAN) && rsp.done;
	assign alloc_retry = scan_done && (op_q == ubt_pkg::OP_ALLOC) && rsp.hit &&
		(count_q != span_q);

	// scan launch: new item, or next ephemeral candidate
	always_comb begin
		req.start    = (in_take && !(in_alloc && range_bad)) || alloc_retry;
		req.use_addr = in_take && (in_beat.operation == ubt_pkg::OP_LOOKUP);
		req.addr     = in_beat.local_addr;
		if (in_take) begin
			req.port = in_alloc ? cur_start : in_beat.port;
		end else begin
			req.port = nxt_cand;
		end
	end

	// table update at scan end
	always_comb begin
		wr.set   = scan_done && (op_q == ubt_pkg::OP_BIND) && !rsp.hit && rsp.free_found;
		wr.clr   = scan_done && (op_q == ubt_pkg::OP_UNBIND) && rsp.hit;
		wr.idx   = wr.set ? rsp.free_idx : rsp.hit_idx;
		wr.port  = port_q;
		wr.addr  = addr_q;
		wr.owner = tag_q;
	end

	// result of a finished scan
	always_comb begin
		res_nxt.status     = ubt_pkg::ST_OK;
		res_nxt.slot       = '0;
		res_nxt.owner_out  = '0;
		res_nxt.alloc_port = '0;
		case (op_q)
			ubt_pkg::OP_BIND: begin
				if (rsp.hit) begin
					res_nxt.status = ubt_pkg::ST_IN_USE;
					res_nxt.slot   = ubt_pkg::SLOT_W'(rsp.hit_idx);
				end else if (rsp.free_found) begin
					res_nxt.slot   = ubt_pkg::SLOT_W'(rsp.free_idx);
				end else begin
					res_nxt.status = ubt_pkg::ST_FULL;
				end
			end
			ubt_pkg::OP_UNBIND: begin
				if (rsp.hit) begin
					res_nxt.slot   = ubt_pkg::SLOT_W'(rsp.hit_idx);
				end else begin
					res_nxt.status = ubt_pkg::ST_NOT_FOUND;
				end
			end
			ubt_pkg::OP_ALLOC: begin
				if (rsp.hit) begin
					res_nxt.status = ubt_pkg::ST_FULL;
				end else begin
					res_nxt.alloc_port = cand_q;
				end
			end
			ubt_pkg::OP_LOOKUP: begin
				if (rsp.hit) begin
					res_nxt.slot      = ubt_pkg::SLOT_W'(rsp.hit_idx);
					res_nxt.owner_out = rsp.hit_owner;
				end else begin
					res_nxt.status = ubt_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				res_nxt.status = ubt_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	// sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= ubt_pkg::CURSOR_RST;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= (in_alloc && range_bad) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_done && !alloc_retry) begin
						state_q <= S_DONE;
						if (op_q == ubt_pkg::OP_ALLOC) begin
							cursor_q <= nxt_cand;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and candidate registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q    <= in_beat.operation;
			port_q  <= in_beat.port;
			addr_q  <= in_beat.local_addr;
			tag_q   <= in_beat.owner_tag;
			cand_q  <= cur_start;
			count_q <= ubt_pkg::CNT_W'(1);
			span_q  <= span;
			res_q.status     <= ubt_pkg::ST_FULL;
			res_q.slot       <= '0;
			res_q.owner_out  <= '0;
			res_q.alloc_port <= '0;
		end else if (alloc_retry) begin
			cand_q  <= nxt_cand;
			count_q <= count_q + ubt_pkg::CNT_W'(1);
		end else if (scan_done) begin
			res_q <= res_nxt;
		end
	end

	assign idle     = state_q == S_IDLE;
	assign res_done = (state_q == S_DONE) && out_free;
	assign res      = res_q;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !out_free) |=> ((state_q == S_DONE) && $stable(res_q)))
		else $error("pending result lost while output busy");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> (state_q == S_IDLE))
		else $error("item taken while busy");

	a_alloc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_done && (op_q == ubt_pkg::OP_ALLOC) && (res_q.status == ubt_pkg::ST_OK)) |->
		((res_q.alloc_port >= eph_low) && (res_q.alloc_port <= eph_high)))
		else $error("allocated port outside range");

endmodule
`default_nettype wire

>>> hw/rtl/udp_port_bind_table_top.sv
`default_nettype none
// UDP port binding table: bind, unbind, ephemeral allocate and lookup over
// ENTRIES slots held in a single-port-read memory.
// Input channel in_valid/in_stall/in_beat carries one operation per beat;
// output channel out_valid/out_stall/out_beat returns exactly one result beat
// per operation, in order. One operation is worked on at a time.
// Bind, unbind and lookup scan the memory one slot per cycle and stop at the
// first match or after the last slot.
// Allocate repeats that scan for each candidate port, trying at most
// min(range size, ENTRIES+1) candidates. An inverted range is answered with
// ST_FULL and no scan. The controller returns to idle as a result enters the
// output register, and the next beat can be accepted from then on.
// Configuration (cfg_we, cfg_idx, cfg_wdata) writes the ephemeral bounds and
// must only be used while no operation is outstanding.
// Reset clears all valid bits at once (no clearing pass), loads the range
// bounds and cursor with their defaults, and empties the output register.
// When out_stall holds a result, the next beat is still accepted and scanned;
// it waits at completion until the output register frees.
module udp_port_bind_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ubt_pkg::in_beat_t             in_beat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ubt_pkg::out_beat_t            out_beat,
	input  logic                          cfg_we,
	input  logic [ubt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ubt_pkg::PORT_W-1:0]    cfg_wdata
);

	logic [ubt_pkg::PORT_W-1:0] eph_low_q;
	logic [ubt_pkg::PORT_W-1:0] eph_high_q;
	logic                       out_valid_q;
	ubt_pkg::out_beat_t         out_beat_q;

	logic                       ctrl_idle;
	logic                       res_done;
	logic                       out_free;
	logic                       in_take;
	ubt_pkg::out_beat_t         res;
	ubt_pkg::scan_req_t         req;
	ubt_pkg::tbl_wr_t           wr;
	ubt_pkg::scan_rsp_t         rsp;

	assign in_stall = !ctrl_idle;
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ephemeral range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eph_low_q  <= ubt_pkg::EPH_LOW_RST;
			eph_high_q <= ubt_pkg::EPH_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ubt_pkg::CFG_EPH_LOW:  eph_low_q  <= cfg_wdata;
				ubt_pkg::CFG_EPH_HIGH: eph_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			out_beat_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	ubt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.in_beat  (in_beat),
		.eph_low  (eph_low_q),
		.eph_high (eph_high_q),
		.out_free (out_free),
		.idle     (ctrl_idle),
		.res_done (res_done),
		.res      (res),
		.req      (req),
		.wr       (wr),
		.rsp      (rsp)
	);

	ubt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.wr     (wr),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

>>> tb/tb_udp_port_bind_table_top.sv
`default_nettype none
module tb_udp_port_bind_table_top;
	import ubt_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	// receiver stall modes
	localparam int STALL_NONE  = 0;
	localparam int STALL_SOME  = 1;
	localparam int STALL_HEAVY = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_beat_t             in_beat = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_beat_t            out_beat;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_EPH_LOW;
	logic [PORT_W-1:0]    cfg_wdata = '0;

	udp_port_bind_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// shadow copy of the binding table and allocator
	logic              bound[ENTRIES];
	logic [PORT_W-1:0] bound_port[ENTRIES];
	logic [ADDR_W-1:0] bound_addr[ENTRIES];
	logic [TAG_W-1:0]  bound_owner[ENTRIES];
	int                eph_lo = 49152;
	int                eph_hi = 65535;
	int                cursor = 49152;

	in_beat_t  op_q[$];      // operations not yet presented
	out_beat_t reply_q[$];   // replies the table still owes, oldest first
	out_beat_t want;
	int        n_issued = 0;
	int        n_taken = 0;
	int        n_replied = 0;
	int        n_fail = 0;
	int        idle_cycles = 0;
	logic      in_fire = 1'b0;

	// stimulus pools, rebuilt per range setting
	logic [PORT_W-1:0] port_pool[12];
	logic [ADDR_W-1:0] addr_pool[3];
	logic [PORT_W-1:0] stray_ports[$];

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			bound[i] = 1'b0;
	end

	function automatic int find_bound(logic [PORT_W-1:0] p);
		for (int i = 0; i < ENTRIES; i++)
			if (bound[i] && bound_port[i] == p)
				return i;
		return -1;
	endfunction

	// apply one operation to the shadow table and return the reply
	function automatic out_beat_t table_apply(in_beat_t b);
		out_beat_t r;
		int hit;
		int cur;
		int span;
		logic [PORT_W-1:0] cand;
		r = '0;
		r.status = ST_OK;
		case (b.operation)
		OP_BIND: begin
			hit = find_bound(b.port);
			if (hit >= 0) begin
				r.status = ST_IN_USE;
				r.slot   = SLOT_W'(hit);
			end else begin
				r.status = ST_FULL;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!bound[i]) begin
						bound[i]       = 1'b1;
						bound_port[i]  = b.port;
						bound_addr[i]  = b.local_addr;
						bound_owner[i] = b.owner_tag;
						r.status       = ST_OK;
						r.slot         = SLOT_W'(i);
						break;
					end
				end
			end
		end
		OP_UNBIND: begin
			hit = find_bound(b.port);
			if (hit >= 0) begin
				bound[hit] = 1'b0;
				r.slot     = SLOT_W'(hit);
			end else
				r.status = ST_NOT_FOUND;
		end
		OP_ALLOC: begin
			r.status = ST_FULL;
			if (eph_lo <= eph_hi) begin
				cur = cursor;
				if (cur < eph_lo || cur > eph_hi)
					cur = eph_lo;
				span = eph_hi - eph_lo + 1;
				for (int n = 0; n < span; n++) begin
					cand = PORT_W'(cur);
					cur  = (cur == eph_hi) ? eph_lo : cur + 1;
					if (find_bound(cand) < 0) begin
						r.status     = ST_OK;
						r.alloc_port = cand;
						break;
					end
				end
				cursor = cur;
			end
		end
		default: begin
			// lookup: port match, stored address wildcard or equal
			r.status = ST_NOT_FOUND;
			for (int i = 0; i < ENTRIES; i++) begin
				if (bound[i] && bound_port[i] == b.port &&
				    (bound_addr[i] == '0 || bound_addr[i] == b.local_addr)) begin
					r.status    = ST_OK;
					r.slot      = SLOT_W'(i);
					r.owner_out = bound_owner[i];
					break;
				end
			end
		end
		endcase
		return r;
	endfunction

	function automatic in_beat_t mk(op_e op, logic [PORT_W-1:0] p, logic [ADDR_W-1:0] a,
	                                logic [TAG_W-1:0] t);
		in_beat_t b;
		b.operation  = op;
		b.port       = p;
		b.local_addr = a;
		b.owner_tag  = t;
		return b;
	endfunction

	// random operation; ports mostly from a small pool so binds, unbinds and
	// lookups keep hitting each other and the allocator has to skip
	function automatic in_beat_t gen_op();
		in_beat_t b;
		int pick;
		pick = $urandom_range(0, 99);
		b.operation = (pick < 35) ? OP_BIND : (pick < 57) ? OP_UNBIND :
		              (pick < 75) ? OP_ALLOC : OP_LOOKUP;
		pick = $urandom_range(0, 9);
		if (b.operation == OP_UNBIND && stray_ports.size() > 0 && pick < 4)
			b.port = stray_ports.pop_front();
		else if (pick < 8)
			b.port = port_pool[$urandom_range(0, 11)];
		else begin
			b.port = PORT_W'($urandom);
			if (b.operation == OP_BIND)
				stray_ports.push_back(b.port);
		end
		pick = $urandom_range(0, 9);
		b.local_addr = (pick < 4) ? '0 : (pick < 7) ? addr_pool[$urandom_range(0, 2)] :
		               ADDR_W'($urandom);
		b.owner_tag = TAG_W'($urandom);
		return b;
	endfunction

	task automatic fill_pools(int lo, int hi);
		port_pool[0] = '0;
		port_pool[1] = '1;
		for (int k = 2; k < 8; k++)
			port_pool[k] = (lo + k - 2 <= hi) ? PORT_W'(lo + k - 2) : PORT_W'($urandom);
		for (int k = 8; k < 12; k++)
			port_pool[k] = PORT_W'($urandom);
		for (int k = 0; k < 3; k++)
			addr_pool[k] = ADDR_W'($urandom);
	endtask

	task automatic push_op(in_beat_t b);
		op_q.push_back(b);
		n_issued++;
	endtask

	task automatic push_random(int n);
		for (int k = 0; k < n; k++)
			push_op(gen_op());
	endtask

	// wait until every issued operation has been answered
	task automatic settle();
		while (n_replied != n_issued)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_range(int lo, int hi);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_EPH_LOW;
		cfg_wdata <= PORT_W'(lo);
		@(negedge clk);
		cfg_idx   <= CFG_EPH_HIGH;
		cfg_wdata <= PORT_W'(hi);
		@(negedge clk);
		cfg_we <= 1'b0;
		eph_lo = lo;
		eph_hi = hi;
		fill_pools(lo, hi);
	endtask

	// sender: bursts of beats with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (op_q.size() > 0) begin
				in_beat  <= op_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern switches between its modes at random times
	int stall_mode = STALL_NONE;
	int stall_timer = 0;
	always @(negedge clk) begin
		if (stall_timer == 0) begin
			stall_mode  = $urandom_range(STALL_NONE, STALL_HEAVY);
			stall_timer = $urandom_range(20, 120);
		end else
			stall_timer--;
		case (stall_mode)
		STALL_NONE: out_stall <= 1'b0;
		STALL_SOME: out_stall <= ($urandom_range(0, 3) == 0);
		default:    out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// monitor: predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				reply_q.push_back(table_apply(in_beat));
				n_taken++;
			end
			if (out_valid && !out_stall) begin
				n_replied++;
				if (reply_q.size() == 0) begin
					$error("reply beat with no operation outstanding: %h", out_beat);
					n_fail++;
				end else begin
					want = reply_q.pop_front();
					if (out_beat.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_beat.status);
						n_fail++;
					end
					if (out_beat.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, out_beat.slot);
						n_fail++;
					end
					if (out_beat.owner_out !== want.owner_out) begin
						$error("owner_out: expected %0d, got %0d", want.owner_out,
						       out_beat.owner_out);
						n_fail++;
					end
					if (out_beat.alloc_port !== want.alloc_port) begin
						$error("alloc_port: expected %0d, got %0d", want.alloc_port,
						       out_beat.alloc_port);
						n_fail++;
					end
				end
			end
			// watchdog on cycles without any beat or register write
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_udp_port_bind_table_top: FAIL");
				$finish;
			end
		end
		in_fire <= arst_n && in_valid && !in_stall;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: misses on an empty table, field extremes, wildcard lookup
		push_op(mk(OP_LOOKUP, '0, '0, '0));
		push_op(mk(OP_UNBIND, '1, '1, '1));
		push_op(mk(OP_BIND, '0, '0, '0));
		push_op(mk(OP_BIND, '1, '1, '1));
		push_op(mk(OP_BIND, '0, 32'h1234_5678, 8'h5a));
		push_op(mk(OP_LOOKUP, '1, '1, '0));
		push_op(mk(OP_LOOKUP, '1, 32'h1234_5678, '0));
		push_op(mk(OP_LOOKUP, '0, 32'hdead_beef, '0));
		// allocator skips a bound port
		push_op(mk(OP_ALLOC, '0, '0, '0));
		push_op(mk(OP_BIND, 16'd49153, 32'h0a00_0001, 8'h11));
		push_op(mk(OP_ALLOC, '1, '1, '1));
		// fill the table, then one bind too many
		for (int i = 0; i < 13; i++)
			push_op(mk(OP_BIND, PORT_W'(1000 + i), ADDR_W'($urandom), TAG_W'($urandom)));
		push_op(mk(OP_BIND, 16'd7, '0, 8'h77));
		push_op(mk(OP_UNBIND, '0, '0, '0));
		push_op(mk(OP_BIND, 16'd7, 32'h0000_0001, 8'h77));
		push_op(mk(OP_LOOKUP, 16'd7, 32'h0000_0001, '0));

		fill_pools(eph_lo, eph_hi);
		push_random(110);
		// tiny range holding port zero, exhausts once bound
		set_range(0, 3);
		push_random(120);
		// single-port range at the top, wraps onto itself
		set_range(65535, 65535);
		push_random(90);
		// inverted range
		set_range(100, 90);
		push_random(60);
		// whole port space
		set_range(0, 65535);
		push_random(120);
		// cursor outside the new range, short wrap
		set_range(1000, 1007);
		push_random(120);
		set_range(49152, 65535);
		push_random(110);

		settle();
		repeat (40) @(posedge clk);
		if (n_fail == 0 && reply_q.size() == 0 && n_taken == n_issued)
			$display("tb_udp_port_bind_table_top: PASS");
		else
			$display("tb_udp_port_bind_table_top: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
